@@ src/alfs_pkg.sv @@
// Shared types, constants and character classes for the assembler line field splitter.
// No dependencies; alfs_datapath, alfs_ctrl and asm_line_field_splitter import this package.
package alfs_pkg;

  localparam logic [2:0] TAG_LABEL   = 3'd0;
  localparam logic [2:0] TAG_MNEM    = 3'd1;
  localparam logic [2:0] TAG_OPER    = 3'd2;
  localparam logic [2:0] TAG_COMMENT = 3'd3;
  localparam logic [2:0] TAG_END     = 3'd4;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_LABEL   = 7'b0000010,
    PH_PREMN   = 7'b0000100,
    PH_MNEM    = 7'b0001000,
    PH_PREOP   = 7'b0010000,
    PH_OPER    = 7'b0100000,
    PH_COMMENT = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EMIT = 4'b0100,
    S_LAST = 4'b1000
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_ram;
    logic load_held;
  } cmd_t;

  typedef struct packed {
    logic flush_req;
    logic rd_last;
    logic out_free;
  } sts_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || is_lower(c);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_trim(input logic [7:0] c);
    return is_sep(c) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic label_first(input logic [7:0] c);
    return is_alpha(c) || (c == CH_UNDER) || (c == CH_AT);
  endfunction

  function automatic logic label_next(input logic [7:0] c);
    return label_first(c) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

  function automatic logic [7:0] upper(input logic [7:0] c);
    return is_lower(c) ? (c - 8'd32) : c;
  endfunction

endpackage

@@ src/alfs_in_if.sv @@
// Input channel: one source byte or an end-of-line transaction.
// Standalone interface, no dependencies.
interface alfs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] ch;

  modport source (output valid, kind, ch, input ready);
  modport sink (input valid, kind, ch, output ready);
endinterface

@@ src/alfs_out_if.sv @@
// Output channel: one tagged character or end-of-line marker per transaction.
// Standalone interface, no dependencies.
interface alfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] field_tag;
  logic       overflow;
  logic       last;

  modport source (output valid, out_char, field_tag, overflow, last, input ready);
  modport sink (input valid, out_char, field_tag, overflow, last, output ready);
endinterface

@@ src/alfs_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module alfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/alfs_datapath.sv @@
// Datapath: line parser, held-whitespace RAM, flush index and output register.
// Depends on alfs_pkg and alfs_ram; driven by alfs_ctrl through cmd_t/sts_t.
module alfs_datapath
  import alfs_pkg::*;
#(
  parameter int PENDING_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       kind,
  input  logic [7:0] ch,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic [2:0] field_tag,
  output logic       overflow,
  output logic       last
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  phase_t        phase;
  phase_t        phase_next;
  logic [CW-1:0] pending_count;
  logic          dropped;
  logic [AW-1:0] rd_idx;
  logic [7:0]    held_char;
  logic [7:0]    ram_rdata;

  logic       d_emit;
  logic [7:0] d_char;
  logic [2:0] d_tag;
  logic       d_ovf;
  logic       d_push;
  logic       d_drop;
  logic       d_clr;
  logic       flush_req;
  logic       full;
  logic       out_free;
  logic       load_new;
  logic       load_any;

  logic       bm_emit;
  logic [7:0] bm_char;
  logic [2:0] bm_tag;
  phase_t     bm_phase;

  assign full     = pending_count == CW'(PENDING_DEPTH);
  assign out_free = !out_valid || out_ready;
  assign load_new = cmd.accept && d_emit;
  assign load_any = load_new || cmd.load_ram || cmd.load_held;

  assign sts.flush_req = flush_req;
  assign sts.rd_last   = (CW'(rd_idx) + CW'(1)) == pending_count;
  assign sts.out_free  = out_free;

  // field entry at line start, after label or after separator
  always_comb begin
    bm_emit  = !is_sep(ch);
    bm_char  = (ch == CH_SEMI) ? ch : upper(ch);
    bm_tag   = (ch == CH_SEMI) ? TAG_COMMENT : TAG_MNEM;
    bm_phase = is_sep(ch) ? PH_PREMN : ((ch == CH_SEMI) ? PH_COMMENT : PH_MNEM);
  end

  always_comb begin
    d_emit     = 1'b0;
    d_char     = ch;
    d_tag      = TAG_OPER;
    d_ovf      = 1'b0;
    d_push     = 1'b0;
    d_drop     = 1'b0;
    d_clr      = 1'b0;
    flush_req  = 1'b0;
    phase_next = phase;
    if (kind) begin
      d_emit     = 1'b1;
      d_char     = 8'd0;
      d_tag      = TAG_END;
      d_ovf      = dropped;
      d_clr      = 1'b1;
      phase_next = PH_START;
    end else begin
      unique case (phase)
        PH_START: begin
          if ((ch == CH_STAR) || (ch == CH_SEMI)) begin
            d_emit     = 1'b1;
            d_tag      = TAG_COMMENT;
            phase_next = PH_COMMENT;
          end else if (label_first(ch)) begin
            d_emit     = 1'b1;
            d_tag      = TAG_LABEL;
            phase_next = PH_LABEL;
          end else begin
            d_emit     = bm_emit;
            d_char     = bm_char;
            d_tag      = bm_tag;
            phase_next = bm_phase;
          end
        end
        PH_LABEL: begin
          if (label_next(ch)) begin
            d_emit = 1'b1;
            d_tag  = TAG_LABEL;
          end else if (ch == CH_COLON) begin
            phase_next = PH_PREMN;
          end else begin
            d_emit     = bm_emit;
            d_char     = bm_char;
            d_tag      = bm_tag;
            phase_next = bm_phase;
          end
        end
        PH_PREMN: begin
          d_emit     = bm_emit;
          d_char     = bm_char;
          d_tag      = bm_tag;
          phase_next = bm_phase;
        end
        PH_MNEM: begin
          if (is_sep(ch)) begin
            phase_next = PH_PREOP;
          end else if (ch == CH_SEMI) begin
            d_emit     = 1'b1;
            d_tag      = TAG_COMMENT;
            phase_next = PH_COMMENT;
          end else begin
            d_emit = 1'b1;
            d_char = upper(ch);
            d_tag  = TAG_MNEM;
          end
        end
        PH_PREOP: begin
          if (ch == CH_SEMI) begin
            d_emit     = 1'b1;
            d_tag      = TAG_COMMENT;
            phase_next = PH_COMMENT;
          end else if (!is_trim(ch)) begin
            d_emit     = 1'b1;
            phase_next = PH_OPER;
          end
        end
        PH_OPER: begin
          if (ch == CH_SEMI) begin
            d_emit     = 1'b1;
            d_tag      = TAG_COMMENT;
            phase_next = PH_COMMENT;
            d_clr      = 1'b1;
          end else if (is_trim(ch)) begin
            d_push = !full;
            d_drop = full;
          end else if (pending_count != '0) begin
            flush_req = 1'b1;
          end else begin
            d_emit = 1'b1;
          end
        end
        default: begin
          d_emit     = 1'b1;
          d_tag      = TAG_COMMENT;
          phase_next = PH_COMMENT;
        end
      endcase
    end
  end

  // end-of-line clears the drop flag; a semicolon only clears the count
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      pending_count <= '0;
      dropped       <= 1'b0;
      rd_idx        <= '0;
    end else begin
      if (cmd.accept) begin
        phase <= phase_next;
        if (d_clr) begin
          pending_count <= '0;
        end else if (d_push) begin
          pending_count <= pending_count + CW'(1);
        end
        if (kind) begin
          dropped <= 1'b0;
        end else if (d_drop) begin
          dropped <= 1'b1;
        end
        if (flush_req) begin
          rd_idx <= '0;
        end
      end
      if (cmd.load_ram) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (cmd.load_held) begin
        pending_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && flush_req) begin
      held_char <= ch;
    end
  end

  alfs_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (cmd.accept && d_push),
    .waddr (pending_count[AW-1:0]),
    .wdata (ch),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_new) begin
      out_char  <= d_char;
      field_tag <= d_tag;
      overflow  <= d_ovf;
      last      <= 1'b1;
    end else if (cmd.load_ram) begin
      out_char  <= ram_rdata;
      field_tag <= TAG_OPER;
      overflow  <= 1'b0;
      last      <= 1'b0;
    end else if (cmd.load_held) begin
      out_char  <= held_char;
      field_tag <= TAG_OPER;
      overflow  <= 1'b0;
      last      <= 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= CW'(PENDING_DEPTH))
    else $error("held whitespace count beyond buffer depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_any |-> out_free)
    else $error("output register loaded while a transaction is pending");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load_held |=> pending_count == '0)
    else $error("held whitespace not cleared after release");

endmodule

@@ src/alfs_ctrl.sv @@
// Controller: input handshake and the sequencer that releases held whitespace.
// Depends on alfs_pkg; commands alfs_datapath.
module alfs_ctrl
  import alfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  assign item_ready = (state == S_IDLE) && sts.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = item_valid && item_ready;
        if (cmd.accept && sts.flush_req) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_ram = 1'b1;
          state_next   = sts.rd_last ? S_LAST : S_READ;
        end
      end
      S_LAST: begin
        if (sts.out_free) begin
          cmd.load_held = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.flush_req) |=> state == S_READ)
    else $error("release sequence did not start");

endmodule

@@ src/asm_line_field_splitter.sv @@
// Assembler line field splitter: takes one source byte or end-of-line transaction
// per cycle while no held whitespace is being released and the output register is
// free or being drained, and returns tagged label, mnemonic, operand and comment
// bytes. An item that yields no result or one result is taken whenever the
// controller is idle and the output register is free or being drained. An operand
// byte after N held whitespace bytes is accepted, then each held byte is read
// from the whitespace buffer's registered read port and loaded out, then the
// byte itself is loaded. The buffer needs no clearing after reset. Depends on
// alfs_pkg, the two interfaces, alfs_ctrl, alfs_datapath and alfs_ram.
module asm_line_field_splitter
  import alfs_pkg::*;
#(
  parameter int PENDING_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  alfs_in_if.sink     item,
  alfs_out_if.source  result
);

  cmd_t cmd;
  sts_t sts;

  alfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  alfs_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .kind      (item.kind),
    .ch        (item.ch),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_char  (result.out_char),
    .field_tag (result.field_tag),
    .overflow  (result.overflow),
    .last      (result.last)
  );

endmodule
